// ----- sv/ssr_pkg.sv -----
// Shared constants, types and configuration indexes for the stream substring replacer.
package ssr_pkg;

    localparam int BYTE_W      = 8;
    localparam int WIN_DEPTH   = 8;
    localparam int WIN_IDX_W   = 3;
    localparam int CNT_W       = 4;
    localparam int JOB_BYTES   = 8;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CNT_W-1:0] MAX_PAT_LEN = 4'd8;
    localparam logic [CNT_W-1:0] MAX_REP_LEN = 4'd8;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_idx;

    // One queued emission job: up to eight bytes, sent oldest first.
    typedef struct packed {
        logic [JOB_BYTES*BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]            nbytes;
        logic                        last;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- sv/ssr_in_if.sv -----
// Input channel carrying source stream bytes.
interface ssr_in_if import ssr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  in_last;

    modport source(output valid, output in_byte, output in_last, input ready);
    modport sink(input valid, input in_byte, input in_last, output ready);
endinterface

// ----- sv/ssr_out_if.sv -----
// Output channel carrying emitted bytes and end markers.
interface ssr_out_if import ssr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  out_has_byte;
    logic  run_last;
    logic  stream_end;

    modport source(output valid, output out_byte, output out_has_byte, output run_last,
                   output stream_end, input ready);
    modport sink(input valid, input out_byte, input out_has_byte, input run_last,
                 input stream_end, output ready);
endinterface

// ----- sv/stream_substring_replace.sv -----
// The first result of a byte is written into the job queue when the byte is taken, then
// loaded into the output register, from which it can be taken.
// Throughput: one input byte per cycle while each byte yields at most one result and the
// job queue is not full; a replacement or a stream-end flush of N bytes is sent as N output
// transactions, and the four-entry job queue absorbs that burst before the input stalls.
// Reset (synchronous, active low) clears the window count, the job queue, the output valid
// flag and all configuration registers; the block is ready the cycle after reset.
module stream_substring_replace import ssr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssr_in_if.sink                i_in_ch,
    ssr_out_if.source             o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_pattern;
    logic [CNT_W-1:0]      r_plen;
    logic [CFG_DATA_W-1:0] r_replacement;
    logic [CNT_W-1:0]      r_rlen;

    logic [CNT_W-1:0] plen_eff;
    logic [CNT_W-1:0] rlen_eff;
    t_push            w_push;
    t_q_stat          w_q_stat;
    t_job             w_head;
    logic             w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern     <= '0;
            r_plen        <= '0;
            r_replacement <= '0;
            r_rlen        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_BYTES:      r_pattern     <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_plen        <= i_cfg_data[CNT_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_replacement <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rlen        <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign plen_eff = (r_plen > MAX_PAT_LEN) ? MAX_PAT_LEN : r_plen;
    assign rlen_eff = (r_rlen > MAX_REP_LEN) ? MAX_REP_LEN : r_rlen;

    ssr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (i_in_ch),
        .i_pattern     (r_pattern),
        .i_plen        (plen_eff),
        .i_replacement (r_replacement),
        .i_rlen        (rlen_eff),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push)
    );

    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    ssr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out_ch (o_out_ch)
    );

    // The front must never push a job into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> !w_q_stat.full)
        else $error("job pushed into a full queue");

    // The back must never pop an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("job popped from an empty queue");

    // An end marker only closes a stream and carries a zero byte.
    a_marker_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.out_has_byte) |->
            (o_out_ch.run_last && o_out_ch.stream_end && o_out_ch.out_byte == '0))
        else $error("malformed end marker");

endmodule

// ----- sv/ssr_front.sv -----
// Front end: keeps the pending window, compares it with the pattern and builds emission jobs.
module ssr_front import ssr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssr_in_if.sink                i_in_ch,
    input  logic [CFG_DATA_W-1:0] i_pattern,
    input  logic [CNT_W-1:0]      i_plen,
    input  logic [CFG_DATA_W-1:0] i_replacement,
    input  logic [CNT_W-1:0]      i_rlen,
    input  t_q_stat               i_q_stat,
    output t_push                 o_push
);

    t_byte            r_win [WIN_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    t_byte            n_win [WIN_DEPTH];
    logic [CNT_W-1:0] n_cnt;

    t_byte            win_p [WIN_DEPTH];
    logic [CNT_W-1:0] cnt_p;
    logic             all_eq;
    logic             match;
    logic             reach;
    logic             accept;
    t_job             job;

    assign i_in_ch.ready = !i_q_stat.full;
    assign accept        = i_in_ch.valid && i_in_ch.ready;

    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_p[i] = (CNT_W'(i) == r_cnt) ? i_in_ch.in_byte : r_win[i];
        end
        cnt_p  = r_cnt + CNT_W'(1);
        all_eq = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (CNT_W'(i) < i_plen && win_p[i] != i_pattern[i*BYTE_W +: BYTE_W]) begin
                all_eq = 1'b0;
            end
        end
        match = (cnt_p == i_plen) && (i_plen != '0) && all_eq;
        reach = (cnt_p >= i_plen);
    end

    always_comb begin
        job.last = i_in_ch.in_last;
        if (match) begin
            job.bytes  = i_replacement;
            job.nbytes = i_rlen;
        end else begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                job.bytes[i*BYTE_W +: BYTE_W] = win_p[i];
            end
            if (i_in_ch.in_last) begin
                job.nbytes = cnt_p;
            end else if (reach) begin
                job.nbytes = CNT_W'(1);
            end else begin
                job.nbytes = '0;
            end
        end
        o_push.job  = job;
        o_push.push = accept && (job.nbytes != '0 || i_in_ch.in_last);
    end

    // The window only shifts on a plain pop; a match or a stream end drains it entirely.
    always_comb begin
        n_win = r_win;
        n_cnt = r_cnt;
        if (accept) begin
            if (match || i_in_ch.in_last) begin
                n_cnt = '0;
            end else if (reach) begin
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    n_win[i] = win_p[i+1];
                end
                n_win[WIN_DEPTH-1] = '0;
                n_cnt = r_cnt;
            end else begin
                n_win = win_p;
                n_cnt = cnt_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- sv/ssr_queue.sv -----
// Small job queue that decouples the window logic from the byte serializer.
module ssr_queue import ssr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push.push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (!i_push.push && i_pop) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/ssr_back.sv -----
// Back end: serializes the head job into one output transaction per byte or end marker.
module ssr_back import ssr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    ssr_out_if.source   o_out_ch
);

    logic [WIN_IDX_W-1:0] r_idx;
    logic                 r_valid;
    t_byte                r_byte;
    logic                 r_has_byte;
    logic                 r_run_last;
    logic                 r_stream_end;

    logic load;
    logic take;
    logic marker;
    logic final_byte;

    assign load       = !r_valid || o_out_ch.ready;
    assign take       = load && !i_q_stat.empty;
    assign marker     = (i_head.nbytes == '0);
    assign final_byte = marker || ({1'b0, r_idx} + CNT_W'(1) == i_head.nbytes);
    assign o_pop      = take && final_byte;

    assign o_out_ch.valid        = r_valid;
    assign o_out_ch.out_byte     = r_byte;
    assign o_out_ch.out_has_byte = r_has_byte;
    assign o_out_ch.run_last     = r_run_last;
    assign o_out_ch.stream_end   = r_stream_end;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte       <= marker ? '0 : i_head.bytes[{r_idx, 3'b000} +: BYTE_W];
            r_has_byte   <= !marker;
            r_run_last   <= final_byte;
            r_stream_end <= final_byte && i_head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_q_stat.empty;
            end
            if (take) begin
                r_idx <= final_byte ? '0 : r_idx + WIN_IDX_W'(1);
            end
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the stream substring replacer: directed and random streams.
`timescale 1ns / 1ps

module tb_top;
    import ssr_pkg::*;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_src_item;

    typedef struct packed {
        t_byte out_byte;
        logic  has_byte;
        logic  run_last;
        logic  stream_end;
    } t_out_rec;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssr_in_if  in_ch();
    ssr_out_if out_ch();

    stream_substring_replace DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Shadow copy of the configuration and of the pending window.
    logic [63:0] pat_bytes_r;
    logic [3:0]  pat_len_r;
    logic [63:0] rep_bytes_r;
    logic [3:0]  rep_len_r;
    t_byte       window_q[$];

    t_src_item source_q[$];
    t_out_rec  predicted_out_q[$];
    t_src_item drv_item;
    t_out_rec  mon_want;

    bit calm;
    int fails;
    int bytes_accepted;
    int results_checked;
    int streams_closed;
    int cfg_writes;
    int queued_items;

    always #2 i_clk = ~i_clk;

    function automatic t_out_rec emitted(input t_byte b, input logic has);
        emitted = '{out_byte: b, has_byte: has, run_last: 1'b0, stream_end: 1'b0};
    endfunction

    // Works out the results that one accepted byte causes.
    task automatic scan_and_replace(input t_byte b, input logic last);
        int       plen;
        int       rlen;
        int       i;
        bit       hit;
        t_out_rec recs[$];
        plen = (pat_len_r > MAX_PAT_LEN) ? MAX_PAT_LEN : pat_len_r;
        rlen = (rep_len_r > MAX_REP_LEN) ? MAX_REP_LEN : rep_len_r;
        if (window_q.size() < WIN_DEPTH)
            window_q.push_back(b);
        if (window_q.size() >= plen) begin
            hit = (window_q.size() == plen) && (plen > 0);
            for (i = 0; i < plen; i++)
                if (window_q[i] != pat_bytes_r[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                for (i = 0; i < rlen; i++)
                    recs.push_back(emitted(rep_bytes_r[8*i +: 8], 1'b1));
                window_q.delete();
            end else begin
                recs.push_back(emitted(window_q.pop_front(), 1'b1));
            end
        end
        if (last) begin
            while (window_q.size() > 0 && recs.size() < 8)
                recs.push_back(emitted(window_q.pop_front(), 1'b1));
            // A stream that ends with nothing to emit still gets an end marker.
            if (recs.size() == 0)
                recs.push_back(emitted(8'h00, 1'b0));
            recs[recs.size()-1].stream_end = 1'b1;
        end
        if (recs.size() > 0)
            recs[recs.size()-1].run_last = 1'b1;
        foreach (recs[k])
            predicted_out_q.push_back(recs[k]);
    endtask

    // Driver: presents the next pending byte once the previous transaction is done.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                scan_and_replace(in_ch.in_byte, in_ch.in_last);
                bytes_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (source_q.size() > 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                    drv_item = source_q.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.in_byte <= drv_item.data;
                    in_ch.in_last <= drv_item.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every output transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (predicted_out_q.size() == 0) begin
                    $error("unexpected result: out_byte %0h has_byte %0b",
                           out_ch.out_byte, out_ch.out_has_byte);
                    fails++;
                end else begin
                    mon_want = predicted_out_q.pop_front();
                    if (out_ch.out_byte !== mon_want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h",
                               mon_want.out_byte, out_ch.out_byte);
                        fails++;
                    end
                    if (out_ch.out_has_byte !== mon_want.has_byte) begin
                        $error("out_has_byte: expected %0b, got %0b",
                               mon_want.has_byte, out_ch.out_has_byte);
                        fails++;
                    end
                    if (out_ch.run_last !== mon_want.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               mon_want.run_last, out_ch.run_last);
                        fails++;
                    end
                    if (out_ch.stream_end !== mon_want.stream_end) begin
                        $error("stream_end: expected %0b, got %0b",
                               mon_want.stream_end, out_ch.stream_end);
                        fails++;
                    end
                    results_checked++;
                    if (mon_want.stream_end)
                        streams_closed++;
                end
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_PATTERN_BYTES:      pat_bytes_r = val;
            CFG_PATTERN_LENGTH:     pat_len_r = val[3:0];
            CFG_REPLACEMENT_BYTES:  rep_bytes_r = val;
            CFG_REPLACEMENT_LENGTH: rep_len_r = val[3:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_config(input logic [63:0] pb, input logic [3:0] pl,
                              input logic [63:0] rb, input logic [3:0] rl);
        write_reg(CFG_PATTERN_BYTES, pb);
        write_reg(CFG_PATTERN_LENGTH, {60'd0, pl});
        write_reg(CFG_REPLACEMENT_BYTES, rb);
        write_reg(CFG_REPLACEMENT_LENGTH, {60'd0, rl});
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic put(input t_byte b, input logic last);
        source_q.push_back('{data: b, last: last});
        queued_items++;
    endtask

    // Builds a stream mostly out of whole and partial pattern copies.
    task automatic queue_stream(input int len, input bit close);
        int    plen;
        int    k;
        int    cut;
        t_byte bytes[$];
        plen = (pat_len_r > MAX_PAT_LEN) ? MAX_PAT_LEN : pat_len_r;
        while (bytes.size() < len) begin
            case ($urandom_range(0, 3))
                0, 1:    cut = plen;
                2:       cut = (plen > 1) ? $urandom_range(1, plen - 1) : 0;
                default: cut = 0;
            endcase
            if (cut == 0)
                bytes.push_back(t_byte'($urandom_range(0, 255)));
            for (k = 0; k < cut; k++)
                bytes.push_back(pat_bytes_r[8*k +: 8]);
        end
        for (k = 0; k < bytes.size(); k++)
            put(bytes[k], close && (k == bytes.size() - 1));
    endtask

    // Waits until every byte is taken and every result is back, then lets the pipe drain.
    task automatic settle();
        while (source_q.size() != 0 || in_ch.valid || predicted_out_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int          phase;
        int          target;
        int          phase_start;
        int          r;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        logic [63:0] pb;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_PATTERN_BYTES;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.in_last = 1'b0;
        out_ch.ready  = 1'b0;
        calm          = 1'b0;
        pat_bytes_r   = '0;
        pat_len_r     = '0;
        rep_bytes_r   = '0;
        rep_len_r     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pass-through with zero pattern length.
        set_config(64'h0, 4'd0, '1, 4'd0);
        put(8'h00, 1'b0);
        put(8'hFF, 1'b1);
        settle();

        // Three-byte pattern, five-byte replacement; a match also lands on the last byte.
        set_config(64'h0000_0000_0063_6261, 4'd3, 64'h0000_00FF_0042_41FF, 4'd5);
        put(8'h61, 1'b0);
        put(8'h62, 1'b0);
        put(8'h63, 1'b0);
        put(8'h78, 1'b0);
        put(8'h61, 1'b0);
        put(8'h62, 1'b0);
        put(8'h63, 1'b1);
        settle();

        // Deletion: a stream that ends right after a match gives only the end marker.
        set_config(64'h0000_0000_0000_FF00, 4'd2, 64'h0, 4'd0);
        put(8'h00, 1'b0);
        put(8'hFF, 1'b1);
        put(8'h00, 1'b0);
        put(8'hFF, 1'b0);
        put(8'h34, 1'b1);
        settle();

        // Both lengths above the maximum are clamped to eight bytes.
        set_config('1, 4'd15, 64'h0, 4'd12);
        repeat (7) put(8'hFF, 1'b0);
        put(8'hFF, 1'b1);
        settle();

        // Shrink the pattern while five bytes are still waiting in the window.
        put(8'h01, 1'b0);
        put(8'h02, 1'b0);
        put(8'h03, 1'b0);
        put(8'h04, 1'b0);
        put(8'h05, 1'b0);
        settle();
        set_config(64'h0000_0000_0000_0201, 4'd2, '1, 4'd8);
        put(8'h06, 1'b1);
        settle();

        // Random phases; a stream may stay open across a configuration change.
        phase = 0;
        phase_start = queued_items;
        while (queued_items - phase_start < 130) begin
            r = $urandom_range(0, 9);
            plen = (r == 0) ? 4'd0 : (r == 9) ? 4'($urandom_range(9, 15)) : 4'(r);
            r = $urandom_range(0, 10);
            rlen = (r > 8) ? 4'($urandom_range(9, 15)) : 4'(r);
            pb = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0)
                pb = pb & 64'h0101_0101_0101_0101;
            calm = (phase == 2);
            set_config(pb, plen, {$urandom, $urandom}, rlen);
            target = queued_items + (calm ? 50 : $urandom_range(10, 30));
            while (queued_items < target)
                queue_stream($urandom_range(1, 12), $urandom_range(0, 4) != 0);
            settle();
            calm = 1'b0;
            phase++;
        end
        put(t_byte'($urandom_range(0, 255)), 1'b1);
        settle();

        $display("Covered %0d input bytes in %0d streams under %0d register writes;",
                 bytes_accepted, streams_closed, cfg_writes);
        $display("%0d results were checked field by field.", results_checked);
        if (fails == 0 && predicted_out_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
